FILE: hw/rtl/mpd_pkg.sv
// Shared constants, codes and record types for the message packet deframer.
// No dependencies; mpd_parser, the top level and the checker use this package.
package mpd_pkg;

  localparam int unsigned LENGTH_BITS = 32;
  localparam logic [31:0] LEN_MAX = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_FAIL    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_FIRST_FAIL    = 3'd0;
  localparam logic [2:0] ERR_FIRST_TIMEOUT = 3'd1;
  localparam logic [2:0] ERR_NO_MARKER     = 3'd2;
  localparam logic [2:0] ERR_NO_MAGIC      = 3'd3;
  localparam logic [2:0] ERR_HDR_SHORT     = 3'd4;
  localparam logic [2:0] ERR_CONT_FAIL     = 3'd5;
  localparam logic [2:0] ERR_CONT_TIMEOUT  = 3'd6;

  localparam logic [1:0] REG_MARKER = 2'd0;
  localparam logic [1:0] REG_MAGIC1 = 2'd1;
  localparam logic [1:0] REG_MAGIC2 = 2'd2;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_MAG1    = 4'd1;
  localparam logic [3:0] PH_MAG2    = 4'd2;
  localparam logic [3:0] PH_TYPE_HI = 4'd3;
  localparam logic [3:0] PH_TYPE_LO = 4'd4;
  localparam logic [3:0] PH_LEN0    = 4'd5;
  localparam logic [3:0] PH_LEN1    = 4'd6;
  localparam logic [3:0] PH_LEN2    = 4'd7;
  localparam logic [3:0] PH_LEN3    = 4'd8;
  localparam logic [3:0] PH_PAYLOAD = 4'd9;
  localparam logic [3:0] PH_CONT    = 4'd10;
  localparam logic [3:0] PH_SKIP    = 4'd11;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       packet_start;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] msg_type;
    logic [31:0] data_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic [2:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic [7:0] marker_value;
    logic [7:0] magic_first;
    logic [7:0] magic_second;
  } cfg_t;

  typedef struct packed {
    logic [3:0]             phase;
    logic [15:0]            type_reg;
    logic [23:0]            len_acc;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [LENGTH_BITS-1:0] received_count;
  } state_t;

endpackage

FILE: hw/rtl/mpd_in_if.sv
// Input channel of the deframer: valid/ready handshake with one packet event.
// No dependencies.
interface mpd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       packet_start;
  logic       packet_end;

  modport source (output valid, action, data_byte, packet_start, packet_end, input ready);
  modport sink   (input valid, action, data_byte, packet_start, packet_end, output ready);
endinterface

FILE: hw/rtl/mpd_out_if.sv
// Output channel of the deframer: valid/ready handshake with one result record.
// No dependencies.
interface mpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] msg_type;
  logic [31:0] data_length;
  logic [7:0]  payload_byte;
  logic        last;
  logic [2:0]  error_code;

  modport source (output valid, kind, msg_type, data_length, payload_byte, last, error_code,
                  input ready);
  modport sink   (input valid, kind, msg_type, data_length, payload_byte, last, error_code,
                  output ready);
endinterface

FILE: hw/rtl/mpd_parser.sv
// Next-state and result logic of the deframer for one registered input event.
// Depends on mpd_pkg.
module mpd_parser (
  input  mpd_pkg::state_t   state_i,
  input  mpd_pkg::cfg_t     cfg_i,
  input  mpd_pkg::in_item_t item_i,
  output mpd_pkg::state_t   state_o,
  output logic              hit_o,
  output mpd_pkg::out_item_t result_o
);

  logic                           do_first;
  logic                           do_pay;
  logic                           fin;
  logic [31:0]                    full;
  logic [31:0]                    sat;
  logic [mpd_pkg::LENGTH_BITS-1:0] cnt_inc;
  logic                           pending;
  logic [7:0]                     b;
  logic                           st;
  logic                           en;

  assign b  = item_i.data_byte;
  assign st = item_i.packet_start;
  assign en = item_i.packet_end;
  assign pending = (state_i.phase == mpd_pkg::PH_PAYLOAD) ||
                   (state_i.phase == mpd_pkg::PH_CONT);
  assign full = {state_i.len_acc, b};
  assign sat = (full > mpd_pkg::LEN_MAX) ? mpd_pkg::LEN_MAX : full;
  assign cnt_inc = state_i.received_count + 1'b1;
  assign fin = (cnt_inc == state_i.length_reg);

  always_comb begin
    state_o  = state_i;
    hit_o    = 1'b0;
    result_o = '0;
    do_first = 1'b0;
    do_pay   = 1'b0;
    case (item_i.action)
      mpd_pkg::ACT_FAIL, mpd_pkg::ACT_TIMEOUT: begin
        state_o.phase       = mpd_pkg::PH_IDLE;
        hit_o               = 1'b1;
        result_o.kind       = mpd_pkg::KIND_ERROR;
        if (item_i.action == mpd_pkg::ACT_FAIL) begin
          result_o.error_code = pending ? mpd_pkg::ERR_CONT_FAIL : mpd_pkg::ERR_FIRST_FAIL;
        end else begin
          result_o.error_code = pending ? mpd_pkg::ERR_CONT_TIMEOUT
                                        : mpd_pkg::ERR_FIRST_TIMEOUT;
        end
      end
      mpd_pkg::ACT_BYTE: begin
        unique case (state_i.phase)
          mpd_pkg::PH_SKIP: begin
            if (st) begin
              do_first = 1'b1;
            end else if (en) begin
              state_o.phase = mpd_pkg::PH_IDLE;
            end
          end
          mpd_pkg::PH_MAG1: begin
            if (b != cfg_i.magic_first || en) begin
              state_o.phase       = en ? mpd_pkg::PH_IDLE : mpd_pkg::PH_SKIP;
              hit_o               = 1'b1;
              result_o.kind       = mpd_pkg::KIND_ERROR;
              result_o.error_code = mpd_pkg::ERR_NO_MAGIC;
            end else begin
              state_o.phase = mpd_pkg::PH_MAG2;
            end
          end
          mpd_pkg::PH_MAG2: begin
            if (b != cfg_i.magic_second) begin
              state_o.phase       = en ? mpd_pkg::PH_IDLE : mpd_pkg::PH_SKIP;
              hit_o               = 1'b1;
              result_o.kind       = mpd_pkg::KIND_ERROR;
              result_o.error_code = mpd_pkg::ERR_NO_MAGIC;
            end else if (en) begin
              state_o.phase       = mpd_pkg::PH_IDLE;
              hit_o               = 1'b1;
              result_o.kind       = mpd_pkg::KIND_ERROR;
              result_o.error_code = mpd_pkg::ERR_HDR_SHORT;
            end else begin
              state_o.phase = mpd_pkg::PH_TYPE_HI;
            end
          end
          mpd_pkg::PH_TYPE_HI, mpd_pkg::PH_TYPE_LO, mpd_pkg::PH_LEN0,
          mpd_pkg::PH_LEN1, mpd_pkg::PH_LEN2: begin
            if (state_i.phase == mpd_pkg::PH_TYPE_HI) begin
              state_o.type_reg = {b, 8'h00};
            end else if (state_i.phase == mpd_pkg::PH_TYPE_LO) begin
              state_o.type_reg = state_i.type_reg | {8'h00, b};
            end else if (state_i.phase == mpd_pkg::PH_LEN0) begin
              state_o.len_acc = {16'h0000, b};
            end else begin
              state_o.len_acc = {state_i.len_acc[15:0], b};
            end
            if (en) begin
              state_o.phase       = mpd_pkg::PH_IDLE;
              hit_o               = 1'b1;
              result_o.kind       = mpd_pkg::KIND_ERROR;
              result_o.error_code = mpd_pkg::ERR_HDR_SHORT;
            end else begin
              state_o.phase = state_i.phase + 4'd1;
            end
          end
          mpd_pkg::PH_LEN3: begin
            state_o.length_reg     = sat[mpd_pkg::LENGTH_BITS-1:0];
            state_o.received_count = '0;
            hit_o                  = 1'b1;
            result_o.kind          = mpd_pkg::KIND_HEADER;
            result_o.msg_type      = state_i.type_reg;
            result_o.data_length   = sat;
            result_o.last          = (sat == 32'd0);
            if (sat == 32'd0) begin
              state_o.phase = en ? mpd_pkg::PH_IDLE : mpd_pkg::PH_SKIP;
            end else begin
              state_o.phase = en ? mpd_pkg::PH_CONT : mpd_pkg::PH_PAYLOAD;
            end
          end
          mpd_pkg::PH_PAYLOAD: begin
            do_pay = 1'b1;
          end
          mpd_pkg::PH_CONT: begin
            if (b == cfg_i.marker_value) begin
              state_o.phase = en ? mpd_pkg::PH_CONT : mpd_pkg::PH_PAYLOAD;
            end else begin
              do_pay = 1'b1;
            end
          end
          default: begin
            state_o.phase = mpd_pkg::PH_IDLE;
            do_first      = st;
          end
        endcase

        if (do_first) begin
          if (b != cfg_i.marker_value) begin
            state_o.phase       = en ? mpd_pkg::PH_IDLE : mpd_pkg::PH_SKIP;
            hit_o               = 1'b1;
            result_o.kind       = mpd_pkg::KIND_ERROR;
            result_o.error_code = mpd_pkg::ERR_NO_MARKER;
          end else if (en) begin
            state_o.phase       = mpd_pkg::PH_IDLE;
            hit_o               = 1'b1;
            result_o.kind       = mpd_pkg::KIND_ERROR;
            result_o.error_code = mpd_pkg::ERR_NO_MAGIC;
          end else begin
            state_o.phase = mpd_pkg::PH_MAG1;
          end
        end

        if (do_pay) begin
          state_o.received_count = cnt_inc;
          hit_o                  = 1'b1;
          result_o.kind          = mpd_pkg::KIND_PAYLOAD;
          result_o.payload_byte  = b;
          result_o.last          = fin;
          if (fin) begin
            state_o.phase = en ? mpd_pkg::PH_IDLE : mpd_pkg::PH_SKIP;
          end else begin
            state_o.phase = en ? mpd_pkg::PH_CONT : mpd_pkg::PH_PAYLOAD;
          end
        end
      end
      default: begin
        hit_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/message_packet_deframer_top.sv
// Top level of the message packet deframer: input register, parser, result register.
// Depends on mpd_pkg, mpd_in_if, mpd_out_if and mpd_parser.
//
// Usage: in_i carries one packet event per transaction (a byte with start and end
// flags, or a read-failure or timeout event). out_o delivers at most one result per
// event: a decoded header (type and length), a payload byte, or a numbered error.
// The config port (cfg_we_i, cfg_index_i, cfg_data_i) sets the marker byte and the
// two magic bytes; write it only while the block is idle.
// An accepted event is loaded into the input register; its result is then loaded into
// the result register once that register is free.
// Throughput: one event per cycle while out_o is not stalled, with the combinational
// parser between the two registers; the state for one byte updates with the result.
// When out_o is stalled the result register holds, the input register fills, and
// in_i.ready falls; nothing is dropped. Events that give no result also wait for a
// free result register.
// Reset: parser goes idle, counters clear, the registers take their default
// values (marker 63, magic 35 and 35), and both registers empty.
module message_packet_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpd_in_if.sink      in_i,
  mpd_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic               s1_valid_q;
  mpd_pkg::in_item_t  s1_item_q;
  mpd_pkg::in_item_t  in_item;
  logic               s1_adv;
  logic               in_fire;
  mpd_pkg::state_t    state_q;
  mpd_pkg::state_t    state_d;
  mpd_pkg::cfg_t      cfg_q;
  logic               hit;
  mpd_pkg::out_item_t result;
  logic               out_valid_q;
  mpd_pkg::out_item_t out_item_q;

  assign in_item.action       = in_i.action;
  assign in_item.data_byte    = in_i.data_byte;
  assign in_item.packet_start = in_i.packet_start;
  assign in_item.packet_end   = in_i.packet_end;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  mpd_parser u_parser (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .hit_o    (hit),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= mpd_pkg::PH_IDLE;
      state_q.type_reg       <= '0;
      state_q.len_acc        <= '0;
      state_q.length_reg     <= '0;
      state_q.received_count <= '0;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.marker_value <= 8'd63;
      cfg_q.magic_first  <= 8'd35;
      cfg_q.magic_second <= 8'd35;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mpd_pkg::REG_MARKER: cfg_q.marker_value <= cfg_data_i;
        mpd_pkg::REG_MAGIC1: cfg_q.magic_first  <= cfg_data_i;
        mpd_pkg::REG_MAGIC2: cfg_q.magic_second <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= hit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && hit) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_item_q.kind;
  assign out_o.msg_type     = out_item_q.msg_type;
  assign out_o.data_length  = out_item_q.data_length;
  assign out_o.payload_byte = out_item_q.payload_byte;
  assign out_o.last         = out_item_q.last;
  assign out_o.error_code   = out_item_q.error_code;

endmodule

FILE: hw/rtl/mpd_checker.sv
// Port-level checks of the message packet deframer, bound to its top level.
// Depends on mpd_pkg and message_packet_deframer_top.
module mpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [31:0] data_length_i,
  input logic [7:0]  payload_byte_i,
  input logic        last_i,
  input logic [2:0]  error_code_i
);

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while result register empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(payload_byte_i) && $stable(error_code_i))
    else $error("stalled result transaction changed");

  a_header_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == mpd_pkg::KIND_HEADER |-> last_i == (data_length_i == 32'd0))
    else $error("header last flag disagrees with length");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == mpd_pkg::KIND_ERROR |->
      error_code_i <= mpd_pkg::ERR_CONT_TIMEOUT && !last_i && data_length_i == 32'd0)
    else $error("malformed error transaction");

  a_valid_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> kind_i != 2'd3)
    else $error("result transaction with unused kind");

endmodule

bind message_packet_deframer_top mpd_checker u_mpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .data_length_i  (out_o.data_length),
  .payload_byte_i (out_o.payload_byte),
  .last_i         (out_o.last),
  .error_code_i   (out_o.error_code)
);
